[sv/jur_pkg.sv]
// Shared types, constants and helper function of the replicate upsampler.
`default_nettype none
package jur_pkg;

    localparam int BLOCK_ROWS = 8;
    localparam int MAX_FACTOR = 4;

    localparam int FACTOR_W = 3;
    localparam int COUNT_W  = 16;
    localparam int ROW_W    = 5;
    localparam int REP_W    = 2;
    localparam int OFFSET_W = 21;
    localparam int SAMPLE_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_HOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_VER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_WID = 3'd5;

    // Commands from the sequencer to the address generator.
    typedef struct packed {
        logic load;     // capture scaled row and column of the new sample
        logic base;     // form the first offset
        logic step;     // advance to the next replicated place
        logic row_end;  // the step leaves the current destination row
    } seq_cmd_t;

    // Integer ratio of two sampling factors, or zero when either factor is
    // out of range or the ratio is not an integer.
    function automatic logic [FACTOR_W-1:0] factor_ratio(
        input logic [FACTOR_W-1:0] max_f,
        input logic [FACTOR_W-1:0] comp_f
    );
        logic [FACTOR_W-1:0] q;
        q = '0;
        if (max_f >= FACTOR_W'(1) && max_f <= FACTOR_W'(MAX_FACTOR) &&
            comp_f >= FACTOR_W'(1) && comp_f <= FACTOR_W'(MAX_FACTOR))
        begin
            for (int k = 1; k <= MAX_FACTOR; k++)
            begin
                if ({3'b000, comp_f} * FACTOR_W'(k) == {3'b000, max_f})
                begin
                    q = FACTOR_W'(k);
                end
            end
        end
        return q;
    endfunction

endpackage
`default_nettype wire

[sv/jpeg_upsample_replicate_unit.sv]
// Top level of the JPEG chroma upsampler by pixel replication.
// Each accepted sample word is written to H by V destination places, with
// H = max_hor_factor / comp_hor_factor and V = max_ver_factor / comp_ver_factor,
// and every place comes out as one output word carrying the destination
// byte offset (row times full_width plus column, low 21 bits), the sample
// and a last flag on the final place of the sample. For each sample the
// source row and column are scaled and registered, then the base offset
// multiply is registered, then one output word per cycle comes from a
// single shared adder while out_ready is high. A sample is consumed with
// no output when a factor is outside 1 to 4 or a ratio is not an integer;
// the column and row counters then stay put. Input is taken
// only while no sample is in progress. Configuration writes are meant to
// happen while the block is idle; they leave the counters untouched.
`default_nettype none
module jpeg_upsample_replicate_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [jur_pkg::SAMPLE_W-1:0]    sample,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [jur_pkg::OFFSET_W-1:0]    dst_offset,
    output logic      [jur_pkg::SAMPLE_W-1:0]    value,
    output logic                                 last,
    input  wire logic                            cfg_we,
    input  wire logic [jur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [jur_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jur_pkg::*;

    logic [FACTOR_W-1:0] max_hor_reg;
    logic [FACTOR_W-1:0] max_ver_reg;
    logic [FACTOR_W-1:0] comp_hor_reg;
    logic [FACTOR_W-1:0] comp_ver_reg;
    logic [COUNT_W-1:0]  src_cols_reg;
    logic [COUNT_W-1:0]  full_width_reg;
    logic [SAMPLE_W-1:0] value_reg;
    logic [FACTOR_W-1:0] hor_ratio;
    logic [FACTOR_W-1:0] ver_ratio;
    logic [COUNT_W-1:0]  col_count;
    logic [ROW_W-1:0]    row_count;
    seq_cmd_t            cmd;

    // Configuration registers. Indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hor_reg    <= FACTOR_W'(1);
            max_ver_reg    <= FACTOR_W'(1);
            comp_hor_reg   <= FACTOR_W'(1);
            comp_ver_reg   <= FACTOR_W'(1);
            src_cols_reg   <= COUNT_W'(8);
            full_width_reg <= COUNT_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_HOR:  max_hor_reg    <= cfg_data[FACTOR_W-1:0];
                REG_MAX_VER:  max_ver_reg    <= cfg_data[FACTOR_W-1:0];
                REG_COMP_HOR: comp_hor_reg   <= cfg_data[FACTOR_W-1:0];
                REG_COMP_VER: comp_ver_reg   <= cfg_data[FACTOR_W-1:0];
                REG_SRC_COLS: src_cols_reg   <= cfg_data;
                REG_FULL_WID: full_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Replication ratios; zero marks an unusable factor combination.
    assign hor_ratio = factor_ratio(max_hor_reg, comp_hor_reg);
    assign ver_ratio = factor_ratio(max_ver_reg, comp_ver_reg);

    // The sample byte is held for all of its replicated output words.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= sample;
        end
    end

    jur_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .last            (last),
        .hor_ratio       (hor_ratio),
        .ver_ratio       (ver_ratio),
        .comp_ver_factor (comp_ver_reg),
        .src_cols        (src_cols_reg),
        .cmd             (cmd),
        .col_count       (col_count),
        .row_count       (row_count)
    );

    jur_addr_gen u_addr_gen (
        .clk        (clk),
        .cmd        (cmd),
        .col_count  (col_count),
        .row_count  (row_count),
        .hor_ratio  (hor_ratio),
        .ver_ratio  (ver_ratio),
        .full_width (full_width_reg),
        .offset     (dst_offset)
    );

    assign value = value_reg;

    // A sample in progress blocks new input.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while an output word is pending");

    // A sample with unusable factors produces no output word.
    a_bad_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (hor_ratio == '0 || ver_ratio == '0))
        |=> (in_ready && !out_valid))
        else $error("output started for an unusable factor combination");

    // Delivering the last word of a sample frees the block for input.
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not ready after the last word of a sample");

    // A usable sample goes through the base state and then presents its first output word.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && hor_ratio != '0 && ver_ratio != '0)
        |=> ##1 out_valid)
        else $error("first output word of a sample not presented in time");

endmodule
`default_nettype wire

[sv/jur_addr_gen.sv]
// Offset generator: scaling multipliers and the shared offset adder.
`default_nettype none
module jur_addr_gen (
    input  wire logic                          clk,
    input  wire jur_pkg::seq_cmd_t             cmd,
    input  wire logic [jur_pkg::COUNT_W-1:0]   col_count,
    input  wire logic [jur_pkg::ROW_W-1:0]     row_count,
    input  wire logic [jur_pkg::FACTOR_W-1:0]  hor_ratio,
    input  wire logic [jur_pkg::FACTOR_W-1:0]  ver_ratio,
    input  wire logic [jur_pkg::COUNT_W-1:0]   full_width,
    output logic      [jur_pkg::OFFSET_W-1:0]  offset
);
    import jur_pkg::*;

    localparam int DROW_W = ROW_W + FACTOR_W;
    localparam int DCOL_W = COUNT_W + FACTOR_W;
    localparam int PROD_W = DROW_W + COUNT_W;

    logic [DROW_W-1:0]   drow_reg;
    logic [DCOL_W-1:0]   dcol_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] row_base_reg;
    logic [PROD_W-1:0]   base_prod;
    logic [OFFSET_W-1:0] base_sum;
    logic [OFFSET_W-1:0] add_a;
    logic [OFFSET_W-1:0] add_b;
    logic [OFFSET_W-1:0] add_sum;

    assign base_prod = PROD_W'(drow_reg) * PROD_W'(full_width);
    assign base_sum  = base_prod[OFFSET_W-1:0] + OFFSET_W'(dcol_reg);

    // One adder walks all replicated places: plus one along a row, plus
    // the stride from the row start when moving down a row.
    assign add_a   = cmd.row_end ? row_base_reg : offset_reg;
    assign add_b   = cmd.row_end ? OFFSET_W'(full_width) : OFFSET_W'(1);
    assign add_sum = add_a + add_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            drow_reg <= DROW_W'(row_count) * DROW_W'(ver_ratio);
            dcol_reg <= DCOL_W'(col_count) * DCOL_W'(hor_ratio);
        end
        if (cmd.base)
        begin
            offset_reg   <= base_sum;
            row_base_reg <= base_sum;
        end
        else if (cmd.step)
        begin
            offset_reg <= add_sum;
            if (cmd.row_end)
            begin
                row_base_reg <= add_sum;
            end
        end
    end

    assign offset = offset_reg;

endmodule
`default_nettype wire

[sv/jur_seq.sv]
// Sequencer: item handshake, replication loop and source position counters.
`default_nettype none
module jur_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               last,
    input  wire logic [jur_pkg::FACTOR_W-1:0]  hor_ratio,
    input  wire logic [jur_pkg::FACTOR_W-1:0]  ver_ratio,
    input  wire logic [jur_pkg::FACTOR_W-1:0]  comp_ver_factor,
    input  wire logic [jur_pkg::COUNT_W-1:0]   src_cols,
    output jur_pkg::seq_cmd_t                  cmd,
    output logic      [jur_pkg::COUNT_W-1:0]   col_count,
    output logic      [jur_pkg::ROW_W-1:0]     row_count
);
    import jur_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BASE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [REP_W-1:0]   h_reg, h_next;
    logic [REP_W-1:0]   v_reg, v_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               ratio_ok;
    logic               accept;
    logic               h_last;
    logic               v_last;
    logic               col_wrap;
    logic               row_wrap;
    logic [ROW_W:0]     rows;

    assign ratio_ok = (hor_ratio != '0) && (ver_ratio != '0);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign h_last   = ({1'b0, h_reg} + FACTOR_W'(1)) == hor_ratio;
    assign v_last   = ({1'b0, v_reg} + FACTOR_W'(1)) == ver_ratio;
    assign out_valid = (state_reg == ST_EMIT);
    assign last     = h_last && v_last;

    assign rows     = (ROW_W+1)'(comp_ver_factor) << 3;
    assign col_wrap = ({1'b0, col_reg} + (COUNT_W+1)'(1)) >= {1'b0, src_cols};
    assign row_wrap = ({1'b0, row_reg} + (ROW_W+1)'(1)) >= rows;

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ratio_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BASE;
                    if (col_wrap)
                    begin
                        col_next = '0;
                        row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + COUNT_W'(1);
                    end
                end
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                h_next     = '0;
                v_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step    = 1'b1;
                        cmd.row_end = h_last;
                        if (h_last)
                        begin
                            h_next = '0;
                            v_next = v_reg + REP_W'(1);
                        end
                        else
                        begin
                            h_next = h_reg + REP_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg     <= '0;
            v_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            v_reg     <= v_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    assign col_count = col_reg;
    assign row_count = row_reg;

endmodule
`default_nettype wire
